[sv/spq_pkg.sv]
package spq_pkg;

  // number of entries in the sorted store
  localparam int unsigned Capacity = 16;
  localparam int unsigned CntW     = $clog2(Capacity + 1);

  // data word reported when the queue is empty
  localparam logic signed [31:0] EmptyWord = 32'sh8000_0000;

  // operation codes of an input transfer
  typedef enum logic [1:0] {
    FUNC_ENQ   = 2'd0,
    FUNC_DEQ   = 2'd1,
    FUNC_QUERY = 2'd2
  } func_e;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] item_value;
    logic signed [15:0] item_priority;
  } in_t;

  typedef struct packed {
    logic signed [31:0] head_value;
    logic signed [31:0] tail_value;
    logic               is_empty;
    logic [4:0]         fill_count;
    logic               underflow;
    logic               overflow;
  } out_t;

  // one stored entry as it moves between neighboring cells
  typedef struct packed {
    logic               valid;
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } entry_t;

  // broadcast command to every cell
  typedef struct packed {
    logic               enq;
    logic               deq;
    logic signed [31:0] item_value;
    logic signed [15:0] item_prio;
  } cell_ctrl_t;

endpackage

[sv/stable_sorted_priority_queue.sv]
// Bounded priority queue of Capacity entries built as a row of cells, each
// holding one entry, kept sorted by signed priority with the front in cell 0.
// An enqueue is inserted behind every entry of greater or equal priority, so
// equal priorities leave in arrival order; a dequeue shifts the row one cell
// toward the front. On each transfer the cells compare against
// the broadcast priority and move in parallel with their neighbors, and the
// result is registered, so one item is accepted per cycle and its result
// appears on the output the next cycle. Input is held off only while a
// result waits on a stalled output. Dequeue of an empty queue sets underflow
// and an enqueue into a full queue is dropped with overflow; head and tail
// read 0x80000000 when empty. fill_count shows the low five bits of the count.
module stable_sorted_priority_queue import spq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic                in_xfer;
  logic                full, empty;
  logic                is_enq, is_deq;
  cell_ctrl_t          ctrl;
  entry_t              cell_entry [Capacity];
  logic [Capacity-1:0] cell_stay;
  logic [Capacity-1:0] cell_tail_ins;
  logic [CntW-1:0]     count_q, count_d;
  logic signed [31:0]  tail_q, tail_d;
  logic signed [31:0]  head_d;
  out_t                out_q, out_d;
  logic                out_valid_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign full  = (count_q == CntW'(Capacity));
  assign empty = (count_q == '0);

  // decode the operation
  always_comb begin
    is_enq = 1'b0;
    is_deq = 1'b0;
    case (in_data_i.func)
      FUNC_ENQ: is_enq = 1'b1;
      FUNC_DEQ: is_deq = 1'b1;
      default:  ;
    endcase
  end

  assign ctrl.enq        = in_xfer && is_enq && !full;
  assign ctrl.deq        = in_xfer && is_deq && !empty;
  assign ctrl.item_value = in_data_i.item_value;
  assign ctrl.item_prio  = in_data_i.item_priority;

  // row of cells, each linked to both neighbors
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_stay;
    if (i == 0) begin : g_front
      assign left_e    = '0;
      assign left_stay = 1'b1;
    end else begin : g_inner
      assign left_e    = cell_entry[i-1];
      assign left_stay = cell_stay[i-1];
    end
    if (i == Capacity - 1) begin : g_rear
      assign right_e = '0;
    end else begin : g_mid
      assign right_e = cell_entry[i+1];
    end
    spq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .left_i      (left_e),
      .left_stay_i (left_stay),
      .right_i     (right_e),
      .entry_o     (cell_entry[i]),
      .stay_o      (cell_stay[i]),
      .tail_ins_o  (cell_tail_ins[i])
    );
  end

  // count, rear word and front word after this transfer
  always_comb begin
    count_d = count_q;
    tail_d  = tail_q;
    head_d  = cell_entry[0].value;
    if (ctrl.enq) begin
      count_d = count_q + 1'b1;
      if (|cell_tail_ins) begin
        tail_d = ctrl.item_value;
      end
      if (!cell_stay[0]) begin
        head_d = ctrl.item_value;
      end
    end else if (ctrl.deq) begin
      count_d = count_q - 1'b1;
      head_d  = cell_entry[1].value;
    end
  end

  // result of this transfer
  always_comb begin
    out_d.is_empty   = (count_d == '0);
    out_d.head_value = out_d.is_empty ? EmptyWord : head_d;
    out_d.tail_value = out_d.is_empty ? EmptyWord : tail_d;
    out_d.fill_count = 5'(count_d);
    out_d.underflow  = is_deq && empty;
    out_d.overflow   = is_enq && full;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tail_q <= tail_d;
    if (in_xfer) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sv/spq_cell.sv]
module spq_cell import spq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     left_i,
  input  logic       left_stay_i,
  input  entry_t     right_i,
  output entry_t     entry_o,
  output logic       stay_o,
  output logic       tail_ins_o
);

  logic               valid_q, valid_d;
  logic signed [31:0] value_q, value_d;
  logic signed [15:0] prio_q, prio_d;
  logic               insert;

  // entry keeps its slot when it ranks at or above the new item
  assign stay_o     = valid_q && (prio_q >= ctrl_i.item_prio);
  assign insert     = ctrl_i.enq && !stay_o && left_stay_i;
  assign tail_ins_o = insert && !valid_q;
  assign entry_o    = '{valid: valid_q, value: value_q, prio: prio_q};

  // next entry: keep, take new item, take left neighbor or take right neighbor
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    prio_d  = prio_q;
    if (ctrl_i.enq) begin
      if (insert) begin
        valid_d = 1'b1;
        value_d = ctrl_i.item_value;
        prio_d  = ctrl_i.item_prio;
      end else if (!stay_o) begin
        valid_d = left_i.valid;
        value_d = left_i.value;
        prio_d  = left_i.prio;
      end
    end else if (ctrl_i.deq) begin
      valid_d = right_i.valid;
      value_d = right_i.value;
      prio_d  = right_i.prio;
    end
  end

  // occupancy bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

endmodule

[sv/spq_checker.sv]
module spq_checker import spq_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // every accepted item yields a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("no result after accepted item");

  // an empty queue reports the empty word and a zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_empty |->
      out_data_o.head_value == EmptyWord && out_data_o.tail_value == EmptyWord &&
      out_data_o.fill_count == 5'd0)
    else $error("empty queue reports data");

  // underflow leaves the queue empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.underflow |-> out_data_o.is_empty)
    else $error("underflow on non-empty queue");

  // one operation cannot both underflow and overflow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.underflow && out_data_o.overflow))
    else $error("underflow and overflow together");

endmodule

bind stable_sorted_priority_queue spq_checker u_spq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
